// File: sv/bcrs_pkg.sv
// Shared constants for the block-decomposed range-sum block.
package bcrs_pkg;

  localparam int unsigned POS_W          = 10;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned ENTRIES_DEF    = 1024;
  localparam int unsigned BLOCK_SIZE_DEF = 32;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

// File: sv/bcrs_mem.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
module bcrs_mem #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bcrs_div.sv
// Constant divider by the block size: quotient and remainder by reciprocal multiplication.
module bcrs_div #(
  parameter int unsigned BLOCK_SIZE = 32,
  parameter int unsigned REM_W      = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bcrs_pkg::POS_W-1:0]  dividend_i,
  output logic                        done_o,
  output logic [bcrs_pkg::POS_W-1:0]  quot_o,
  output logic [REM_W-1:0]            rem_o
);

  import bcrs_pkg::*;

  localparam int unsigned SH = POS_W + 9;
  localparam int unsigned PW = POS_W + SH;
  localparam logic [SH-1:0]    RECIP = SH'((2 ** SH + BLOCK_SIZE - 1) / BLOCK_SIZE);
  localparam logic [POS_W-1:0] BS_C  = POS_W'(BLOCK_SIZE);

  logic             done_q, done_d;
  logic [PW-1:0]    prod;
  logic [POS_W-1:0] quot_q, quot_d;
  logic [REM_W-1:0] rem_q, rem_d;

  always_comb begin
    prod   = PW'(dividend_i) * PW'(RECIP);
    quot_d = prod[PW-1:SH];
    rem_d  = REM_W'(dividend_i - quot_d * BS_C);
    done_d = start_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// File: sv/block_decomposed_range_sum.sv
// Range-sum block over an entry memory and a block-total memory.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_stall_o    cmd_i position_i delta_i range_first_i
//                                                  range_last_i
//   out      source     out_valid_o / out_stall_i  range_total_o
//
// After reset a clearing pass writes zero to every entry of both memories; no
// transfer is taken meanwhile.
// One item at a time. Add: a divide, a read and a write back, in that order.
// Query: a divide, then one memory read per cycle over the walk, at most
// 2*(BLOCK_SIZE-1)+NB-2 reads in all, then a drain to the output register.
// An empty or inverted range goes straight to drain and yields zero.
// A stalled result holds in the output register; the next item is taken meanwhile,
// and a later query waits in drain until that result transfers.
module block_decomposed_range_sum #(
  parameter int unsigned ENTRIES    = bcrs_pkg::ENTRIES_DEF,
  parameter int unsigned BLOCK_SIZE = bcrs_pkg::BLOCK_SIZE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic [bcrs_pkg::POS_W-1:0]         position_i,
  input  logic signed [bcrs_pkg::DATA_W-1:0] delta_i,
  input  logic [bcrs_pkg::POS_W-1:0]         range_first_i,
  input  logic [bcrs_pkg::POS_W-1:0]         range_last_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [bcrs_pkg::DATA_W-1:0] range_total_o
);

  import bcrs_pkg::*;

  localparam int unsigned NB = (ENTRIES + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned BW = (NB > 1) ? $clog2(NB) : 1;
  localparam int unsigned RW = $clog2(BLOCK_SIZE);
  localparam int unsigned XW = POS_W + 1;

  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_CLEAR  = 3'd0;
  localparam logic [ST_W-1:0] ST_IDLE   = 3'd1;
  localparam logic [ST_W-1:0] ST_DIV    = 3'd2;
  localparam logic [ST_W-1:0] ST_ADD_WR = 3'd3;
  localparam logic [ST_W-1:0] ST_WALK   = 3'd4;
  localparam logic [ST_W-1:0] ST_DRAIN  = 3'd5;

  logic [ST_W-1:0]   state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              pend_q, pend_d;
  logic              pend_tot_q, pend_tot_d;
  logic              out_valid_q, out_valid_d;

  logic              cmd_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] delta_q;
  logic [XW-1:0]     last_q;
  logic [XW-1:0]     idx_q, idx_d;
  logic [XW-1:0]     blk_q, blk_d;
  logic [RW-1:0]     off_q, off_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] range_total_q, range_total_d;

  logic              in_xfer;
  logic [XW-1:0]     last_sat;
  logic              first_ok;
  logic              pos_ok;
  logic              walk_end;
  logic              take_tot;

  logic              div_start;
  logic              div_done;
  logic [POS_W-1:0]  div_quot;
  logic [RW-1:0]     div_rem;

  logic              ent_we, ent_re;
  logic [AW-1:0]     ent_waddr, ent_raddr;
  logic [DATA_W-1:0] ent_wdata, ent_rdata;
  logic              tot_we, tot_re;
  logic [BW-1:0]     tot_waddr, tot_raddr;
  logic [DATA_W-1:0] tot_wdata, tot_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign last_sat = (32'(range_last_i) >= ENTRIES) ? XW'(ENTRIES - 1) : XW'(range_last_i);
  assign first_ok = (32'(range_first_i) < ENTRIES) && (XW'(range_first_i) <= last_sat);
  assign pos_ok   = (32'(position_i) < ENTRIES);

  assign walk_end = (idx_q > last_q);
  assign take_tot = (off_q == '0) && ((idx_q + XW'(BLOCK_SIZE - 1)) <= last_q);

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    idx_d         = idx_q;
    blk_d         = blk_q;
    off_d         = off_q;
    pend_d        = 1'b0;
    pend_tot_d    = 1'b0;
    acc_d         = pend_q ? (acc_q + (pend_tot_q ? tot_rdata : ent_rdata)) : acc_q;
    out_valid_d   = out_valid_q && out_stall_i;
    range_total_d = range_total_q;
    div_start     = 1'b0;
    ent_we        = 1'b0;
    ent_waddr     = AW'(pos_q);
    ent_wdata     = ent_rdata + delta_q;
    ent_re        = 1'b0;
    ent_raddr     = AW'(idx_q);
    tot_we        = 1'b0;
    tot_waddr     = BW'(blk_q);
    tot_wdata     = tot_rdata + delta_q;
    tot_re        = 1'b0;
    tot_raddr     = BW'(blk_q);

    unique case (state_q)
      ST_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_q;
        ent_wdata = '0;
        tot_we    = (32'(clr_q) < NB);
        tot_waddr = BW'(clr_q);
        tot_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          idx_d = XW'(range_first_i);
          acc_d = '0;
          if (cmd_i == CMD_ADD) begin
            if (pos_ok) begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end else if (first_ok) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          blk_d = XW'(div_quot);
          if (cmd_q == CMD_ADD) begin
            ent_re    = 1'b1;
            ent_raddr = AW'(pos_q);
            tot_re    = 1'b1;
            tot_raddr = BW'(div_quot);
            state_d   = ST_ADD_WR;
          end else begin
            off_d   = div_rem;
            state_d = ST_WALK;
          end
        end
      end
      ST_ADD_WR: begin
        ent_we  = 1'b1;
        tot_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_WALK: begin
        if (walk_end) begin
          state_d = ST_DRAIN;
        end else if (take_tot) begin
          tot_re     = 1'b1;
          pend_d     = 1'b1;
          pend_tot_d = 1'b1;
          idx_d      = idx_q + XW'(BLOCK_SIZE);
          blk_d      = blk_q + 1'b1;
        end else begin
          ent_re = 1'b1;
          pend_d = 1'b1;
          idx_d  = idx_q + 1'b1;
          if (off_q == RW'(BLOCK_SIZE - 1)) begin
            off_d = '0;
            blk_d = blk_q + 1'b1;
          end else begin
            off_d = off_q + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (!pend_q && (!out_valid_q || !out_stall_i)) begin
          out_valid_d   = 1'b1;
          range_total_d = acc_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      pend_tot_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      pend_tot_q  <= pend_tot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q   <= cmd_i;
      pos_q   <= position_i;
      delta_q <= delta_i;
      last_q  <= last_sat;
    end
    idx_q         <= idx_d;
    blk_q         <= blk_d;
    off_q         <= off_d;
    acc_q         <= acc_d;
    range_total_q <= range_total_d;
  end

  bcrs_div #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .REM_W      (RW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ((cmd_i == CMD_ADD) ? position_i : range_first_i),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  bcrs_mem #(
    .DEPTH  (ENTRIES),
    .ADDR_W (AW),
    .DATA_W (DATA_W)
  ) u_entry_mem (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  bcrs_mem #(
    .DEPTH  (NB),
    .ADDR_W (BW),
    .DATA_W (DATA_W)
  ) u_total_mem (
    .clk_i   (clk_i),
    .we_i    (tot_we),
    .waddr_i (tot_waddr),
    .wdata_i (tot_wdata),
    .re_i    (tot_re),
    .raddr_i (tot_raddr),
    .rdata_o (tot_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign range_total_o = range_total_q;

endmodule

// File: sv/bcrs_checker.sv
// Port-level checks for the range-sum block, bound to the top level.
module bcrs_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               cmd_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [bcrs_pkg::DATA_W-1:0] range_total_o
);

  import bcrs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(range_total_o))
    else $error("stalled result changed or dropped");

  a_add_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == CMD_ADD) && !out_valid_o |=> !out_valid_o)
    else $error("result appeared right after an add transfer");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == CMD_QUERY) |=> in_stall_o)
    else $error("input not stalled while a query is in progress");

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised without a query in progress");

endmodule

bind block_decomposed_range_sum bcrs_checker u_bcrs_checker (.*);
